// ===== design/cmde_pkg.sv =====
// Package for the colouring move-delta engine.
// Holds the operation codes and error codes shared by the engine and its checker.
// No dependencies.
package cmde_pkg;

    // Operation codes carried in the request's tuser.
    localparam logic [2:0] OP_CLEAR     = 3'd0;
    localparam logic [2:0] OP_ADD_EDGE  = 3'd1;
    localparam logic [2:0] OP_SET       = 3'd2;
    localparam logic [2:0] OP_QUERY     = 3'd3;
    localparam logic [2:0] OP_APPLY     = 3'd4;
    localparam logic [2:0] OP_RECOUNT   = 3'd5;

    // Error codes returned with every result.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_VERTEX   = 2'd1;
    localparam logic [1:0] ERR_COLOUR   = 2'd2;
    localparam logic [1:0] ERR_FULL     = 2'd3;

    // Register indexes on the configuration port.
    localparam logic CFG_VERTEX_COUNT   = 1'b0;
    localparam logic CFG_COLOUR_COUNT   = 1'b1;

endpackage

// ===== design/cmde_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the colour, neighbour-count and neighbour-list stores.
// No dependencies.
module cmde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/colouring_move_delta_engine.sv =====
// Move-delta engine for min-conflicts graph colouring. One request is worked at a time and the
// block drops s_tready until it is done; a finished result waits in an output register so the
// next request can be taken meanwhile. A query or apply move scans the neighbour list one entry
// per cycle through the list memory's single read port, each entry's colour being read in the
// cycle after its list read. Clear graph sweeps the neighbour-count memory, and recount scans
// the list of each of the MAX_VERTICES vertices in turn. After reset the block runs a clearing
// pass over the neighbour counts before it takes its first request; configuration writes are
// taken at any time.
// Depends on cmde_pkg and cmde_ram.
module colouring_move_delta_engine
    import cmde_pkg::*;
#(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_DEGREE   = 64,
    parameter int MAX_COLOURS  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // vertex[9:0], other_vertex[19:10], colour[27:20], zeros
    input  logic [2:0]  s_tuser,   // op[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // conflict_delta[7:0], total_conflicts[23:8],
                                   // error_code[25:24], zeros
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int KW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int NCW = $clog2(MAX_DEGREE + 1);
    localparam int CWD = (MAX_COLOURS > 1) ? $clog2(MAX_COLOURS) : 1;
    localparam int DLW = NCW + 1;
    localparam int SW  = $clog2(MAX_VERTICES * MAX_DEGREE + 1);
    localparam int LAW = VAW + KW;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_DECODE, ST_CLEAR, ST_EDGE_RDV, ST_EDGE_RDW, ST_EDGE_CHK,
        ST_EDGE_WR1, ST_EDGE_WR2, ST_Q_RD, ST_Q_LAT, ST_SCAN, ST_REC_RD, ST_REC_LAT, ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [10:0]             vcount_reg, vcount_next;
    logic [8:0]              ccount_reg, ccount_next;
    logic [15:0]             total_reg, total_next;
    logic [2:0]              op_reg, op_next;
    logic [9:0]              v_reg, v_next;
    logic [9:0]              w_reg, w_next;
    logic [7:0]              c_reg, c_next;
    logic [VAW-1:0]          clr_reg, clr_next;
    logic [VAW-1:0]          x_reg, x_next;
    logic [VAW-1:0]          base_reg, base_next;
    logic [NCW-1:0]          cnt_reg, cnt_next;
    logic [NCW-1:0]          k_reg, k_next;
    logic [NCW-1:0]          cv_reg, cv_next;
    logic [NCW-1:0]          cw_reg, cw_next;
    logic [CWD-1:0]          cur_reg, cur_next;
    logic                    p1_reg, p1_next;
    logic                    p2_reg, p2_next;
    logic [VAW-1:0]          u2_reg, u2_next;
    logic signed [DLW-1:0]   acc_reg, acc_next;
    logic [SW-1:0]           sum_reg, sum_next;
    logic [7:0]              delta_reg, delta_next;
    logic [1:0]              err_reg, err_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [31:0]             m_tdata_reg, m_tdata_next;

    // Memory ports.
    logic                    col_we;
    logic [VAW-1:0]          col_waddr, col_raddr;
    logic [CWD-1:0]          col_wdata, col_rdata;
    logic                    cnt_we;
    logic [VAW-1:0]          cnt_waddr, cnt_raddr;
    logic [NCW-1:0]          cnt_wdata, cnt_rdata;
    logic                    lst_we;
    logic [LAW-1:0]          lst_waddr, lst_raddr;
    logic [VAW-1:0]          lst_wdata, lst_rdata;

    // Range checks and helper values.
    logic                    v_ok, w_ok, c_ok, self_loop, list_full, scan_done, issue;
    logic [VAW-1:0]          v_addr, w_addr;
    logic [CWD-1:0]          c_ext;
    logic [NCW-1:0]          cv_inc;
    logic signed [31:0]      delta32;
    logic [7:0]              delta_sat;
    logic signed [17:0]      total_ext, acc_ext, tsum;
    logic [15:0]             total_moved;
    logic [SW-1:0]           half_sum;
    logic [15:0]             total_recount;

    cmde_ram #(.WIDTH(CWD), .DEPTH(MAX_VERTICES)) u_colour_ram (
        .clk(clk), .we(col_we), .waddr(col_waddr), .wdata(col_wdata),
        .raddr(col_raddr), .rdata(col_rdata)
    );

    cmde_ram #(.WIDTH(NCW), .DEPTH(MAX_VERTICES)) u_count_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    cmde_ram #(.WIDTH(VAW), .DEPTH(MAX_VERTICES * (2 ** KW))) u_list_ram (
        .clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
        .raddr(lst_raddr), .rdata(lst_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Range checks on the latched request.
    assign v_ok = (32'(v_reg) < 32'(vcount_reg)) && (32'(v_reg) < MAX_VERTICES);
    assign w_ok = (32'(w_reg) < 32'(vcount_reg)) && (32'(w_reg) < MAX_VERTICES);
    assign c_ok = (32'(c_reg) < 32'(ccount_reg)) && (32'(c_reg) < MAX_COLOURS);
    assign v_addr = VAW'(v_reg);
    assign w_addr = VAW'(w_reg);
    assign c_ext  = CWD'(c_reg);
    assign self_loop = (v_reg == w_reg);
    assign cv_inc = NCW'(32'(cv_reg) + 1);
    assign list_full = self_loop ? (32'(cv_reg) + 2 > MAX_DEGREE)
                                 : ((32'(cv_reg) >= MAX_DEGREE) ||
                                    (32'(cnt_rdata) >= MAX_DEGREE));

    // Scan control: issue one list read per cycle until the count is reached.
    assign issue     = (k_reg < cnt_reg);
    assign scan_done = !issue && !p1_reg && !p2_reg;

    // Saturated delta for the result.
    assign delta32   = 32'(acc_reg);
    assign delta_sat = (delta32 > 32'sd127)  ? 8'sd127 :
                       (delta32 < -32'sd128) ? 8'h80 : 8'(delta32);

    // Running total after a move, held to 0..65535.
    assign total_ext   = {2'b00, total_reg};
    assign acc_ext     = 18'(acc_reg);
    assign tsum        = total_ext + acc_ext;
    assign total_moved = (tsum < 18'sd0) ? 16'd0 :
                         (tsum > 18'sd65535) ? 16'hFFFF : 16'(tsum);

    // Recount total: every conflicting edge was seen from both ends.
    assign half_sum      = sum_reg >> 1;
    assign total_recount = (32'(half_sum) > 32'd65535) ? 16'hFFFF : 16'(half_sum);

    // Sequencer next-state and memory control.
    always_comb
    begin
        state_next    = state_reg;
        vcount_next   = vcount_reg;
        ccount_next   = ccount_reg;
        total_next    = total_reg;
        op_next       = op_reg;
        v_next        = v_reg;
        w_next        = w_reg;
        c_next        = c_reg;
        clr_next      = clr_reg;
        x_next        = x_reg;
        base_next     = base_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        cv_next       = cv_reg;
        cw_next       = cw_reg;
        cur_next      = cur_reg;
        p1_next       = 1'b0;
        p2_next       = 1'b0;
        u2_next       = u2_reg;
        acc_next      = acc_reg;
        sum_next      = sum_reg;
        delta_next    = delta_reg;
        err_next      = err_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        col_we    = 1'b0;
        col_waddr = v_addr;
        col_wdata = c_ext;
        col_raddr = base_reg;
        cnt_we    = 1'b0;
        cnt_waddr = clr_reg;
        cnt_wdata = '0;
        cnt_raddr = v_addr;
        lst_we    = 1'b0;
        lst_waddr = {v_addr, cv_reg[KW-1:0]};
        lst_wdata = w_addr;
        lst_raddr = {base_reg, k_reg[KW-1:0]};

        // Configuration writes.
        if (cfg_we)
        begin
            if (cfg_index == CFG_VERTEX_COUNT)
            begin
                vcount_next = cfg_data;
            end
            else
            begin
                ccount_next = cfg_data[8:0];
            end
        end

        // The output register drains independently of the sequencer.
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                cnt_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == MAX_VERTICES - 1)
                begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    v_next     = s_tdata[9:0];
                    w_next     = s_tdata[19:10];
                    c_next     = s_tdata[27:20];
                    delta_next = '0;
                    err_next   = ERR_NONE;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (op_reg)
                    OP_CLEAR:
                    begin
                        clr_next   = '0;
                        total_next = '0;
                        state_next = ST_CLEAR;
                    end
                    OP_ADD_EDGE:
                    begin
                        if (!v_ok || !w_ok)
                        begin
                            err_next   = ERR_VERTEX;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_EDGE_RDV;
                        end
                    end
                    OP_SET:
                    begin
                        if (!v_ok)
                        begin
                            err_next = ERR_VERTEX;
                        end
                        else if (!c_ok)
                        begin
                            err_next = ERR_COLOUR;
                        end
                        else
                        begin
                            col_we = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    OP_QUERY, OP_APPLY:
                    begin
                        base_next = v_addr;
                        if (!v_ok)
                        begin
                            err_next   = ERR_VERTEX;
                            state_next = ST_DONE;
                        end
                        else if (!c_ok)
                        begin
                            err_next   = ERR_COLOUR;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_Q_RD;
                        end
                    end
                    OP_RECOUNT:
                    begin
                        x_next     = '0;
                        sum_next   = '0;
                        state_next = ST_REC_RD;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            // Add edge: read both counts, check space, then write both lists.
            ST_EDGE_RDV:
            begin
                cnt_raddr  = v_addr;
                state_next = ST_EDGE_RDW;
            end
            ST_EDGE_RDW:
            begin
                cv_next    = cnt_rdata;
                cnt_raddr  = w_addr;
                state_next = ST_EDGE_CHK;
            end
            ST_EDGE_CHK:
            begin
                cw_next = cnt_rdata;
                if (list_full)
                begin
                    err_next   = ERR_FULL;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_EDGE_WR1;
                end
            end
            ST_EDGE_WR1:
            begin
                lst_we    = 1'b1;
                lst_waddr = {v_addr, cv_reg[KW-1:0]};
                lst_wdata = w_addr;
                cnt_we    = 1'b1;
                cnt_waddr = v_addr;
                cnt_wdata = self_loop ? NCW'(32'(cv_reg) + 2) : cv_inc;
                state_next = ST_EDGE_WR2;
            end
            ST_EDGE_WR2:
            begin
                lst_we = 1'b1;
                if (self_loop)
                begin
                    lst_waddr = {v_addr, cv_inc[KW-1:0]};
                    lst_wdata = v_addr;
                end
                else
                begin
                    lst_waddr = {w_addr, cw_reg[KW-1:0]};
                    lst_wdata = v_addr;
                    cnt_we    = 1'b1;
                    cnt_waddr = w_addr;
                    cnt_wdata = NCW'(32'(cw_reg) + 1);
                end
                state_next = ST_DONE;
            end
            // Query and apply: fetch count and current colour, then scan.
            ST_Q_RD:
            begin
                cnt_raddr  = base_reg;
                col_raddr  = base_reg;
                state_next = ST_Q_LAT;
            end
            ST_Q_LAT, ST_REC_LAT:
            begin
                cnt_next   = cnt_rdata;
                cur_next   = col_rdata;
                k_next     = '0;
                acc_next   = '0;
                state_next = ST_SCAN;
            end
            ST_REC_RD:
            begin
                base_next  = x_reg;
                cnt_raddr  = x_reg;
                col_raddr  = x_reg;
                state_next = ST_REC_LAT;
            end
            // Neighbour scan: list read, then colour read of that neighbour, then compare.
            // An unchanged colour leaves the delta at zero.
            ST_SCAN:
            begin
                lst_raddr = {base_reg, k_reg[KW-1:0]};
                col_raddr = lst_rdata;
                if (issue)
                begin
                    p1_next = 1'b1;
                    k_next  = k_reg + 1'b1;
                end
                if (p1_reg)
                begin
                    p2_next = 1'b1;
                    u2_next = lst_rdata;
                end
                if (p2_reg && (32'(u2_reg) < MAX_VERTICES))
                begin
                    if (op_reg == OP_RECOUNT)
                    begin
                        if (col_rdata == cur_reg)
                        begin
                            sum_next = sum_reg + 1'b1;
                        end
                    end
                    else if ((u2_reg != base_reg) && (cur_reg != c_ext))
                    begin
                        if (col_rdata == c_ext)
                        begin
                            acc_next = acc_reg + 2'sd1;
                        end
                        else if (col_rdata == cur_reg)
                        begin
                            acc_next = acc_reg - 2'sd1;
                        end
                    end
                end
                if (scan_done)
                begin
                    if (op_reg == OP_RECOUNT)
                    begin
                        if (32'(x_reg) == MAX_VERTICES - 1)
                        begin
                            total_next = total_recount;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            x_next     = x_reg + 1'b1;
                            state_next = ST_REC_RD;
                        end
                    end
                    else
                    begin
                        delta_next = delta_sat;
                        if (op_reg == OP_APPLY)
                        begin
                            total_next = total_moved;
                            col_we     = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            // Hand the result to the output register once it is free.
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, err_reg, total_reg, delta_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            vcount_reg   <= 11'd1024;
            ccount_reg   <= 9'd4;
            total_reg    <= '0;
            clr_reg      <= '0;
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            vcount_reg   <= vcount_next;
            ccount_reg   <= ccount_next;
            total_reg    <= total_next;
            clr_reg      <= clr_next;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        v_reg       <= v_next;
        w_reg       <= w_next;
        c_reg       <= c_next;
        x_reg       <= x_next;
        base_reg    <= base_next;
        cnt_reg     <= cnt_next;
        k_reg       <= k_next;
        cv_reg      <= cv_next;
        cw_reg      <= cw_next;
        cur_reg     <= cur_next;
        u2_reg      <= u2_next;
        acc_reg     <= acc_next;
        sum_reg     <= sum_next;
        delta_reg   <= delta_next;
        err_reg     <= err_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== design/cmde_checker.sv =====
// Port-level checker for the colouring move-delta engine, bound to the top level.
// Depends on cmde_pkg and colouring_move_delta_engine.
module cmde_checker
    import cmde_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // One request at a time: the engine is busy right after taking one.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // Any error comes with a zero delta.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[25:24] != ERR_NONE) |-> (m_tdata[7:0] == 8'd0))
        else $error("nonzero delta on error");

    // Padding bits of the result stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:26] == 6'd0))
        else $error("result padding not zero");

endmodule

bind colouring_move_delta_engine cmde_checker u_cmde_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the colouring move-delta engine.
// It drives requests on the stream port, predicts every result with a model of the graph
// state, and compares the results field by field. Depends on cmde_pkg and the engine.
module tb_top;
    import cmde_pkg::*;

    // Codes the engine ignores.
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int NV  = 1024;
    localparam int DEG = 64;
    localparam int NC  = 256;

    typedef struct {
        logic signed [7:0] delta;
        logic [15:0]       total;
        logic [1:0]        err;
    } outcome_t;

    typedef struct {
        logic [2:0]  op;
        int          v;
        int          w;
        int          c;
        bit          typed;
        int          d;
        int          t;
        logic [1:0]  e;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [10:0] cfg_data;

    // Shadow of the engine state.
    int colour_of [NV];
    bit coloured  [NV];
    int degree    [NV];
    int adjacency [NV*DEG];
    int conflict_sum;
    int vertex_limit;
    int colour_limit;

    outcome_t pending_results[$];
    int mismatch_count;
    int requests_sent;
    int results_seen;
    int full_refusals;
    bit idle_on;
    bit hold_req;

    colouring_move_delta_engine dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock with a 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Hard stop in case the engine hangs.
    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic bit vertex_valid(int v);
        return v < vertex_limit && v < NV;
    endfunction

    function automatic bit colour_valid(int c);
        return c < colour_limit && c < NC;
    endfunction

    // A vertex may be addressed only if its colour will never be read before it is written.
    function automatic bit vertex_safe(int v);
        return !vertex_valid(v) || coloured[v];
    endfunction

    // Neighbours of v, other than v itself, that carry colour c.
    function automatic int same_colour_neighbours(int v, int c);
        int n;
        n = 0;
        for (int k = 0; k < degree[v]; k++)
        begin
            if (adjacency[v*DEG+k] != v && colour_of[adjacency[v*DEG+k]] == c)
                n++;
        end
        return n;
    endfunction

    // Applies one request to the shadow state and returns the result it must produce.
    task automatic compute_outcome(input logic [2:0] op, input int v, input int w, input int c,
                                   output outcome_t res);
        int  delta;
        int  sum;
        logic [1:0] err;
        delta = 0;
        err = ERR_NONE;
        case (op)
            OP_CLEAR:
            begin
                for (int i = 0; i < NV; i++)
                    degree[i] = 0;
                conflict_sum = 0;
            end
            OP_ADD_EDGE:
            begin
                if (!vertex_valid(v) || !vertex_valid(w))
                    err = ERR_VERTEX;
                else if (v == w)
                begin
                    if (degree[v] + 2 > DEG)
                        err = ERR_FULL;
                    else
                    begin
                        adjacency[v*DEG+degree[v]] = v;
                        adjacency[v*DEG+degree[v]+1] = v;
                        degree[v] += 2;
                    end
                end
                else if (degree[v] >= DEG || degree[w] >= DEG)
                    err = ERR_FULL;
                else
                begin
                    adjacency[v*DEG+degree[v]] = w;
                    adjacency[w*DEG+degree[w]] = v;
                    degree[v]++;
                    degree[w]++;
                end
            end
            OP_SET:
            begin
                if (!vertex_valid(v))
                    err = ERR_VERTEX;
                else if (!colour_valid(c))
                    err = ERR_COLOUR;
                else
                begin
                    colour_of[v] = c;
                    coloured[v] = 1'b1;
                end
            end
            OP_QUERY, OP_APPLY:
            begin
                if (!vertex_valid(v))
                    err = ERR_VERTEX;
                else if (!colour_valid(c))
                    err = ERR_COLOUR;
                else
                begin
                    if (colour_of[v] != c)
                        delta = same_colour_neighbours(v, c)
                              - same_colour_neighbours(v, colour_of[v]);
                    if (op == OP_APPLY)
                    begin
                        conflict_sum += delta;
                        if (conflict_sum < 0)
                            conflict_sum = 0;
                        if (conflict_sum > 65535)
                            conflict_sum = 65535;
                        colour_of[v] = c;
                        coloured[v] = 1'b1;
                    end
                end
            end
            OP_RECOUNT:
            begin
                sum = 0;
                for (int x = 0; x < NV; x++)
                begin
                    for (int k = 0; k < degree[x]; k++)
                    begin
                        if (colour_of[adjacency[x*DEG+k]] == colour_of[x])
                            sum++;
                    end
                end
                sum = sum / 2;
                conflict_sum = (sum > 65535) ? 65535 : sum;
            end
            default:
            begin
            end
        endcase
        if (delta > 127)
            delta = 127;
        if (delta < -128)
            delta = -128;
        if (err == ERR_FULL)
            full_refusals++;
        res.delta = delta[7:0];
        res.total = conflict_sum[15:0];
        res.err = err;
    endtask

    task automatic report(input string field, input int got, input int want);
        $display("ERROR %0t: %s got %0d expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    // Sends one request; typed rows carry their own expected result.
    task automatic send_request(input logic [2:0] op, input int v, input int w, input int c,
                                input bit typed = 0, input int d = 0, input int t = 0,
                                input logic [1:0] e = ERR_NONE);
        int r;
        int gap;
        outcome_t res;
        r = $urandom_range(0, 99);
        gap = 0;
        if (idle_on && r >= 70)
            gap = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, c[7:0], w[9:0], v[9:0]};
        do
            @(posedge clk);
        while (!s_tready);
        compute_outcome(op, v, w, c, res);
        if (typed)
        begin
            res.delta = d[7:0];
            res.total = t[15:0];
            res.err = e;
        end
        pending_results.insert(pending_results.size(), res);
        requests_sent++;
        @(negedge clk);
    endtask

    // Writes one register once every result is back.
    task automatic write_register(input logic index, input int value);
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[10:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_VERTEX_COUNT)
            vertex_limit = value & 'h7FF;
        else
            colour_limit = value & 'h1FF;
    endtask

    function automatic int pick_vertex();
        int i;
        if ($urandom_range(0, 9) < 8)
        begin
            i = $urandom_range(0, 15);
            return (i == 15) ? 1023 : i;
        end
        return $urandom_range(0, 1023);
    endfunction

    function automatic int pick_colour();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 255);
    endfunction

    // Random mix of operations, mostly over a small vertex pool.
    task automatic random_requests(input int count);
        int r;
        int v;
        int w;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            v = pick_vertex();
            w = pick_vertex();
            if (!vertex_safe(v))
                v = 0;
            if (!vertex_safe(w))
                w = 0;
            if (r < 3)
                send_request(OP_CLEAR, v, w, pick_colour());
            else if (r < 5)
                send_request(OP_RECOUNT, v, w, pick_colour());
            else if (r < 7)
                send_request(r[0] ? OP_SPARE_A : OP_SPARE_B, $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom_range(0, 255));
            else if (r < 30)
                send_request(OP_ADD_EDGE, v, w, pick_colour());
            else if (r < 50)
                send_request(OP_SET, $urandom_range(0, 1023), w, pick_colour());
            else if (r < 75)
                send_request(OP_QUERY, v, w, pick_colour());
            else
                send_request(OP_APPLY, v, w, pick_colour());
        end
    endtask

    // Fills one vertex's list until an edge is refused, then probes the full vertex.
    task automatic fill_vertex(input int v);
        for (int n = 0; n < 66; n++)
            send_request(OP_ADD_EDGE, v, (n % 4 == 0) ? v : $urandom_range(0, 14), 0);
        send_request(OP_QUERY, v, 0, 1);
        send_request(OP_APPLY, v, 0, 2);
        send_request(OP_RECOUNT, 0, 0, 0);
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report("unexpected result, delta", $signed(m_tdata[7:0]), 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.delta)
                    report("conflict_delta", $signed(m_tdata[7:0]), want.delta);
                if (m_tdata[23:8] !== want.total)
                    report("total_conflicts", m_tdata[23:8], want.total);
                if (m_tdata[25:24] !== want.err)
                    report("error_code", m_tdata[25:24], want.err);
            end
        end
    end

    // Receiver back-pressure, including one long hold-off on request.
    initial
    begin
        int hold_cycles;
        int rgap;
        int r;
        hold_cycles = 0;
        rgap = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cycles = 400;
            end
            r = $urandom_range(0, 99);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (rgap > 0)
            begin
                rgap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on && r < 15)
                    rgap = $urandom_range(1, 3);
                else if (idle_on && r < 18)
                    rgap = $urandom_range(20, 60);
            end
        end
    end

    // Main sequence.
    initial
    begin
        row_t directed [18];
        int   phase_vertices [7];
        int   phase_colours [7];
        directed = '{
            '{OP_QUERY,    0,    0,    4,   1, 0, 0, ERR_COLOUR},
            '{OP_SET,      1023, 0,    3,   1, 0, 0, ERR_NONE},
            '{OP_SET,      0,    0,    0,   1, 0, 0, ERR_NONE},
            '{OP_SET,      1,    0,    0,   1, 0, 0, ERR_NONE},
            '{OP_SET,      2,    0,    1,   1, 0, 0, ERR_NONE},
            '{OP_ADD_EDGE, 0,    1,    0,   1, 0, 0, ERR_NONE},
            '{OP_ADD_EDGE, 1023, 1023, 255, 1, 0, 0, ERR_NONE},
            '{OP_ADD_EDGE, 0,    1023, 0,   1, 0, 0, ERR_NONE},
            '{OP_SPARE_A,  1023, 1023, 255, 1, 0, 0, ERR_NONE},
            '{OP_SPARE_B,  0,    0,    0,   1, 0, 0, ERR_NONE},
            '{OP_RECOUNT,  0,    0,    0,   0, 0, 0, ERR_NONE},
            '{OP_QUERY,    0,    0,    3,   0, 0, 0, ERR_NONE},
            '{OP_QUERY,    0,    0,    0,   0, 0, 0, ERR_NONE},
            '{OP_APPLY,    0,    0,    3,   0, 0, 0, ERR_NONE},
            '{OP_APPLY,    1023, 0,    0,   0, 0, 0, ERR_NONE},
            '{OP_SET,      2,    0,    255, 0, 0, 0, ERR_COLOUR},
            '{OP_CLEAR,    0,    0,    0,   1, 0, 0, ERR_NONE},
            '{OP_ADD_EDGE, 2,    2,    0,   0, 0, 0, ERR_NONE}
        };
        phase_vertices = '{1024, 1, 16, 0, 2047, 12, 1024};
        phase_colours  = '{4, 2, 256, 511, 0, 3, 256};

        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_CLEAR;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_VERTEX_COUNT;
        cfg_data = '0;
        hold_req = 1'b0;
        idle_on = 1'b1;
        mismatch_count = 0;
        requests_sent = 0;
        results_seen = 0;
        full_refusals = 0;
        conflict_sum = 0;
        vertex_limit = 1024;
        colour_limit = 4;
        for (int i = 0; i < NV; i++)
        begin
            colour_of[i] = 0;
            coloured[i] = 1'b0;
            degree[i] = 0;
        end

        // Reset, released at a falling edge.
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows.
        foreach (directed[i])
            send_request(directed[i].op, directed[i].v, directed[i].w, directed[i].c,
                         directed[i].typed, directed[i].d, directed[i].t, directed[i].e);

        // Give every pool vertex a colour before random traffic touches it.
        for (int i = 0; i < 16; i++)
            send_request(OP_SET, (i == 15) ? 1023 : i, 0, $urandom_range(0, 3));

        // Random phases, each under its own register setting.
        for (int p = 0; p < 7; p++)
        begin
            write_register(CFG_VERTEX_COUNT, phase_vertices[p]);
            write_register(CFG_COLOUR_COUNT, phase_colours[p]);
            idle_on = (p != 5);
            if (p == 1)
                hold_req = 1'b1;
            random_requests(25);
            if (p == 3)
            begin
                s_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
            end
            random_requests(30);
            if (p == 2 || p == 6)
                fill_vertex($urandom_range(3, 14));
        end

        // Drain and let the engine settle.
        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (200) @(posedge clk);
        $display("Run covered %0d requests and %0d results over 7 register settings,",
                 requests_sent, results_seen);
        $display("with %0d full-list refusals and %0d mismatches.",
                 full_refusals, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
